// ===== design/go_back_n_arq_window_defines.svh =====
// Assertion macros for the Go-Back-N window checker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef GO_BACK_N_ARQ_WINDOW_DEFINES_SVH
`define GO_BACK_N_ARQ_WINDOW_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define GBN_CHECK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gbn check failed");

// Next-cycle implication, disabled during reset.
`define GBN_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gbn check failed");

`endif

// ===== design/gbn_pkg.sv =====
// Shared constants and codes for the Go-Back-N window block.
// No dependencies.
`default_nettype none

package gbn_pkg;

  localparam int MAX_SEQ_NUM  = 7;
  localparam int SEQ_MOD      = MAX_SEQ_NUM + 1;
  localparam int SEQ_BITS     = $clog2(SEQ_MOD);
  localparam int PAYLOAD_BITS = 32;
  localparam int CMD_BITS     = 2;
  localparam int KIND_BITS    = 2;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_PACKET    = 2'd0,
    CMD_FRAME     = 2'd1,
    CMD_CKSUM_ERR = 2'd2,
    CMD_TIMEOUT   = 2'd3
  } cmd_t;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_TX      = 2'd0,
    KIND_DELIVER = 2'd1,
    KIND_STATUS  = 2'd2,
    KIND_REFUSED = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_RES  = 4'b0100,
    ST_RTX  = 4'b1000
  } state_t;

endpackage

`default_nettype wire

// ===== design/gbn_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module gbn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/go_back_n_arq_window.sv =====
// Go-Back-N sliding-window endpoint; uses gbn_pkg and gbn_ram (send buffer).
// Packet, frame and checksum-error requests: registered on accept, evaluated in
// ST_EXEC and held in ST_RES until out_ready, then the next request is accepted.
// Timeout, N frames outstanding: N results, one per cycle while out_ready is high,
// paced by the send buffer's registered read port; then the next request is taken.
// Synchronous reset clears the window counters; the send buffer is not cleared.
`default_nettype none

module go_back_n_arq_window (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [gbn_pkg::CMD_BITS-1:0]      cmd,
  input  wire logic [gbn_pkg::PAYLOAD_BITS-1:0]  data_word,
  input  wire logic [gbn_pkg::SEQ_BITS-1:0]      rx_seq,
  input  wire logic [gbn_pkg::SEQ_BITS-1:0]      rx_ack,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [gbn_pkg::KIND_BITS-1:0]          kind,
  output logic [gbn_pkg::SEQ_BITS-1:0]           tx_seq,
  output logic [gbn_pkg::SEQ_BITS-1:0]           tx_ack,
  output logic [gbn_pkg::PAYLOAD_BITS-1:0]       out_word,
  output logic [gbn_pkg::SEQ_BITS-1:0]           freed_count,
  output logic                                   net_enable,
  output logic                                   last
);

  import gbn_pkg::*;

  localparam logic [SEQ_BITS-1:0] SEQ_ONE  = SEQ_BITS'(1);
  localparam logic [SEQ_BITS-1:0] SEQ_ZERO = '0;
  localparam logic [SEQ_BITS-1:0] SEQ_FULL = SEQ_BITS'(MAX_SEQ_NUM);

  state_t                  state, state_next;
  logic [SEQ_BITS-1:0]     next_to_send, next_to_send_next;
  logic [SEQ_BITS-1:0]     oldest_unacked, oldest_unacked_next;
  logic [SEQ_BITS-1:0]     expected_rx, expected_rx_next;
  logic [SEQ_BITS-1:0]     outstanding, outstanding_next;
  logic [SEQ_BITS-1:0]     cursor, cursor_next;
  logic [SEQ_BITS-1:0]     count, count_next;

  cmd_t                    cmd_r;
  logic [PAYLOAD_BITS-1:0] word_r;
  logic [SEQ_BITS-1:0]     rseq_r;
  logic [SEQ_BITS-1:0]     rack_r;

  kind_t                   kind_r, kind_next;
  logic [SEQ_BITS-1:0]     seq_r, seq_next;
  logic [SEQ_BITS-1:0]     ack_r, ack_next;
  logic [PAYLOAD_BITS-1:0] word_out_r, word_out_next;
  logic [SEQ_BITS-1:0]     freed_r, freed_next;
  logic                    net_r, net_next;

  logic                    ram_we;
  logic                    ram_re;
  logic [SEQ_BITS-1:0]     ram_raddr;
  logic [PAYLOAD_BITS-1:0] ram_rdata;

  logic [SEQ_BITS-1:0]     ack_field;
  logic [SEQ_BITS-1:0]     ack_dist;
  logic [SEQ_BITS-1:0]     cursor_inc;
  logic                    rtx_last;

  gbn_ram #(
    .WIDTH (PAYLOAD_BITS),
    .DEPTH (SEQ_MOD)
  ) u_send_buffer (
    .clk   (clk),
    .we    (ram_we),
    .waddr (next_to_send),
    .wdata (word_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ack_field  = expected_rx - SEQ_ONE;
  assign ack_dist   = rack_r - oldest_unacked;
  assign cursor_inc = cursor + SEQ_ONE;
  assign rtx_last   = (count + SEQ_ONE) == outstanding;

  always_comb begin
    state_next          = state;
    next_to_send_next   = next_to_send;
    oldest_unacked_next = oldest_unacked;
    expected_rx_next    = expected_rx;
    outstanding_next    = outstanding;
    cursor_next         = cursor;
    count_next          = count;
    kind_next           = kind_r;
    seq_next            = seq_r;
    ack_next            = ack_r;
    word_out_next       = word_out_r;
    freed_next          = freed_r;
    net_next            = net_r;
    ram_we              = 1'b0;
    ram_re              = 1'b0;
    ram_raddr           = cursor;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next    = ST_RES;
        kind_next     = KIND_STATUS;
        seq_next      = SEQ_ZERO;
        ack_next      = SEQ_ZERO;
        word_out_next = '0;
        freed_next    = SEQ_ZERO;
        unique case (cmd_r)
          CMD_PACKET: begin
            if (outstanding == SEQ_FULL) begin
              kind_next = KIND_REFUSED;
            end else begin
              ram_we            = 1'b1;
              outstanding_next  = outstanding + SEQ_ONE;
              next_to_send_next = next_to_send + SEQ_ONE;
              kind_next         = KIND_TX;
              seq_next          = next_to_send;
              ack_next          = ack_field;
              word_out_next     = word_r;
            end
          end
          CMD_FRAME: begin
            if (rseq_r == expected_rx) begin
              expected_rx_next = expected_rx + SEQ_ONE;
              kind_next        = KIND_DELIVER;
              word_out_next    = word_r;
            end
            if (ack_dist < outstanding) begin
              freed_next          = ack_dist + SEQ_ONE;
              outstanding_next    = outstanding - (ack_dist + SEQ_ONE);
              oldest_unacked_next = oldest_unacked + (ack_dist + SEQ_ONE);
            end
          end
          CMD_CKSUM_ERR: begin
          end
          CMD_TIMEOUT: begin
            if (outstanding != SEQ_ZERO) begin
              cursor_next = oldest_unacked;
              count_next  = SEQ_ZERO;
              ram_re      = 1'b1;
              ram_raddr   = oldest_unacked;
              state_next  = ST_RTX;
            end
          end
        endcase
        net_next = outstanding_next < SEQ_FULL;
      end
      ST_RES: begin
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      ST_RTX: begin
        if (out_ready) begin
          if (rtx_last) begin
            next_to_send_next = cursor_inc;
            state_next        = ST_IDLE;
          end else begin
            cursor_next = cursor_inc;
            count_next  = count + SEQ_ONE;
            ram_re      = 1'b1;
            ram_raddr   = cursor_inc;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      next_to_send   <= '0;
      oldest_unacked <= '0;
      expected_rx    <= '0;
      outstanding    <= '0;
      cursor         <= '0;
      count          <= '0;
    end else begin
      state          <= state_next;
      next_to_send   <= next_to_send_next;
      oldest_unacked <= oldest_unacked_next;
      expected_rx    <= expected_rx_next;
      outstanding    <= outstanding_next;
      cursor         <= cursor_next;
      count          <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r  <= cmd_t'(cmd);
      word_r <= data_word;
      rseq_r <= rx_seq;
      rack_r <= rx_ack;
    end
    kind_r     <= kind_next;
    seq_r      <= seq_next;
    ack_r      <= ack_next;
    word_out_r <= word_out_next;
    freed_r    <= freed_next;
    net_r      <= net_next;
  end

  assign in_ready    = state == ST_IDLE;
  assign out_valid   = (state == ST_RES) || (state == ST_RTX);
  assign kind        = (state == ST_RTX) ? KIND_TX : kind_r;
  assign tx_seq      = (state == ST_RTX) ? cursor : seq_r;
  assign tx_ack      = (state == ST_RTX) ? ack_field : ack_r;
  assign out_word    = (state == ST_RTX) ? ram_rdata : word_out_r;
  assign freed_count = (state == ST_RTX) ? SEQ_ZERO : freed_r;
  assign net_enable  = (state == ST_RTX) ? (outstanding < SEQ_FULL) : net_r;
  assign last        = (state == ST_RTX) ? rtx_last : 1'b1;

endmodule

`default_nettype wire

// ===== design/gbn_checker.sv =====
// Port-level checks for go_back_n_arq_window, bound to the top level.
// Uses gbn_pkg and the macros in go_back_n_arq_window_defines.svh.
`default_nettype none
`include "go_back_n_arq_window_defines.svh"

module gbn_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [gbn_pkg::KIND_BITS-1:0]     kind,
  input wire logic [gbn_pkg::SEQ_BITS-1:0]      tx_seq,
  input wire logic [gbn_pkg::SEQ_BITS-1:0]      tx_ack,
  input wire logic [gbn_pkg::SEQ_BITS-1:0]      freed_count,
  input wire logic                              net_enable,
  input wire logic                              last
);

  import gbn_pkg::*;

  `GBN_CHECK_NOW(a_refused_full, out_valid && kind == KIND_REFUSED, last && !net_enable)
  `GBN_CHECK_NOW(a_no_seq_off_tx, out_valid && kind != KIND_TX, tx_seq == '0 && tx_ack == '0)
  `GBN_CHECK_NOW(a_freed_on_frame, out_valid && freed_count != '0,
                 kind == KIND_DELIVER || kind == KIND_STATUS)
  `GBN_CHECK_NEXT(a_replay_continues, out_valid && out_ready && !last,
                  out_valid && !in_ready)
  `GBN_CHECK_NEXT(a_accept_then_busy, in_valid && in_ready, !out_valid && !in_ready)

endmodule

bind go_back_n_arq_window gbn_checker u_gbn_checker (.*);

`default_nettype wire
